>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, idle under arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define SHB_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// When pre holds, post must hold in the next cycle.
`define SHB_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> sv/shb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_pkg
// Shared types and constants of the string hash bucket block.
// ----------------------------------------------------------------------------
package shb_pkg;

	localparam int unsigned HASH_W   = 32;
	localparam int unsigned BUCKET_W = 16;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned MODE_W   = 3;

	// hash modes
	localparam logic [MODE_W-1:0] MODE_ZERO  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FIRST = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SUM   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_XOR   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ROTL  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ROTR  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_CRC32 = 3'd6;

	// configuration register indexes
	localparam logic [0:0] CFG_IDX_MODE    = 1'b0;
	localparam logic [0:0] CFG_IDX_BUCKETS = 1'b1;

	localparam logic [MODE_W-1:0]   MODE_RESET    = MODE_CRC32;
	localparam logic [BUCKET_W-1:0] BUCKETS_RESET = 16'd1024;

	localparam logic [HASH_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [HASH_W-1:0] CRC_POLY = 32'hEDB8_8320;

	// one remainder step per hash bit
	localparam int unsigned DIV_STEPS = HASH_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_HOLD = 3'b100
	} shb_state_t;

	typedef struct packed {
		logic fold;    // non-terminating byte accepted
		logic start;   // terminator accepted: latch hash, load divider
		logic step;    // one remainder step
		logic commit;  // load result register
	} shb_cmd_t;

	typedef struct packed {
		logic is_term; // byte on the input is the terminator
	} shb_sts_t;

endpackage

>>> sv/shb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_char_if / shb_result_if
// Valid/ready channels for input bytes and hash results.
// ----------------------------------------------------------------------------
interface shb_char_if;
	logic                              valid;
	logic                              ready;
	logic [shb_pkg::CHAR_W-1:0]        char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink   (input valid, input char_byte, output ready);
endinterface

interface shb_result_if;
	logic                              valid;
	logic                              ready;
	logic [shb_pkg::HASH_W-1:0]        hash_value;
	logic [shb_pkg::BUCKET_W-1:0]      bucket_index;

	modport source (output valid, output hash_value, output bucket_index, input ready);
	modport sink   (input valid, input hash_value, input bucket_index, output ready);
endinterface

>>> sv/shb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_ctrl
// Sequencer: byte intake, remainder step count, result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  shb_pkg::shb_sts_t  sts,
	output shb_pkg::shb_cmd_t  cmd
);

	localparam logic [shb_pkg::DIV_CNT_W-1:0] CNT_LAST =
		shb_pkg::DIV_CNT_W'(shb_pkg::DIV_STEPS - 1);

	shb_pkg::shb_state_t               state_q;
	logic [shb_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic                              out_valid_q;
	logic                              take;
	logic                              slot_free;

	assign in_ready  = (state_q == shb_pkg::ST_IDLE);
	assign take      = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.fold   = take && !sts.is_term;
		cmd.start  = take && sts.is_term;
		cmd.step   = (state_q == shb_pkg::ST_DIV);
		cmd.commit = (state_q == shb_pkg::ST_HOLD) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= shb_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				shb_pkg::ST_IDLE: begin
					if (cmd.start) begin
						state_q <= shb_pkg::ST_DIV;
						cnt_q   <= '0;
					end
				end
				shb_pkg::ST_DIV: begin
					cnt_q <= cnt_q + shb_pkg::DIV_CNT_W'(1);
					if (cnt_q == CNT_LAST)
						state_q <= shb_pkg::ST_HOLD;
				end
				shb_pkg::ST_HOLD: begin
					if (cmd.commit)
						state_q <= shb_pkg::ST_IDLE;
				end
				default: state_q <= shb_pkg::ST_IDLE;
			endcase
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	`SHB_ASSERT_ALWAYS(a_commit_slot_free, !cmd.commit || !out_valid_q || out_ready, "result overwritten before taken")
	`SHB_ASSERT_NEXT(a_start_enters_div, cmd.start, state_q == shb_pkg::ST_DIV && cnt_q == '0, "terminator did not start division")
	`SHB_ASSERT_NEXT(a_div_ends, state_q == shb_pkg::ST_DIV && cnt_q == CNT_LAST, state_q == shb_pkg::ST_HOLD, "division overran its step count")
	`SHB_ASSERT_ALWAYS(a_no_intake_busy, !(in_ready && (cnt_q != '0) && state_q != shb_pkg::ST_IDLE), "byte taken while busy")

endmodule

>>> sv/shb_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_dpath
// Config registers, running hash, serial remainder unit, result register.
// ----------------------------------------------------------------------------
module shb_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [0:0]                       cfg_index,
	input  logic [shb_pkg::BUCKET_W-1:0]     cfg_data,
	input  logic [shb_pkg::CHAR_W-1:0]       char_byte,
	input  shb_pkg::shb_cmd_t                cmd,
	output shb_pkg::shb_sts_t                sts,
	output logic [shb_pkg::HASH_W-1:0]       hash_value,
	output logic [shb_pkg::BUCKET_W-1:0]     bucket_index
);

	function automatic logic [shb_pkg::HASH_W-1:0] init_for(
		input logic [shb_pkg::MODE_W-1:0] mode);
		return (mode == shb_pkg::MODE_CRC32) ? shb_pkg::ALL_ONES : '0;
	endfunction

	function automatic logic [shb_pkg::HASH_W-1:0] fold_byte(
		input logic [shb_pkg::MODE_W-1:0] mode,
		input logic [shb_pkg::HASH_W-1:0] h,
		input logic [shb_pkg::CHAR_W-1:0] b,
		input logic                       first);
		logic [shb_pkg::HASH_W-1:0] bx;
		logic [shb_pkg::HASH_W-1:0] c;
		logic [shb_pkg::HASH_W-1:0] r;
		bx = {{(shb_pkg::HASH_W - shb_pkg::CHAR_W){1'b0}}, b};
		c  = h ^ bx;
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ shb_pkg::CRC_POLY) : (c >> 1);
		unique case (mode)
			shb_pkg::MODE_FIRST: r = first ? bx : h;
			shb_pkg::MODE_SUM:   r = h + bx;
			shb_pkg::MODE_XOR:   r = h ^ bx;
			shb_pkg::MODE_ROTL:  r = {h[shb_pkg::HASH_W-2:0], h[shb_pkg::HASH_W-1]} ^ bx;
			shb_pkg::MODE_ROTR:  r = {h[0], h[shb_pkg::HASH_W-1:1]} ^ bx;
			shb_pkg::MODE_CRC32: r = c;
			default:             r = '0;
		endcase
		return r;
	endfunction

	logic [shb_pkg::MODE_W-1:0]      mode_q;
	logic [shb_pkg::BUCKET_W-1:0]    buckets_q;
	logic [shb_pkg::HASH_W-1:0]      run_q;
	logic                            at_start_q;

	logic [shb_pkg::HASH_W-1:0]      hash_q;     // finished hash
	logic [shb_pkg::HASH_W-1:0]      dvd_q;      // dividend, shifted out msb first
	logic [shb_pkg::BUCKET_W-1:0]    dsr_q;
	logic [shb_pkg::BUCKET_W-1:0]    rem_q;
	logic [shb_pkg::HASH_W-1:0]      hash_out_q;
	logic [shb_pkg::BUCKET_W-1:0]    bucket_out_q;

	logic [shb_pkg::HASH_W-1:0]      base;
	logic [shb_pkg::HASH_W-1:0]      final_hash;
	logic [shb_pkg::BUCKET_W:0]      trial;
	logic [shb_pkg::BUCKET_W:0]      diff;

	assign sts.is_term = (char_byte == '0);

	assign base = at_start_q ? init_for(mode_q) : run_q;

	always_comb begin
		if (at_start_q)
			final_hash = '0;
		else if (mode_q == shb_pkg::MODE_CRC32)
			final_hash = ~run_q;
		else
			final_hash = run_q;
	end

	assign trial = {rem_q, dvd_q[shb_pkg::HASH_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= shb_pkg::MODE_RESET;
			buckets_q  <= shb_pkg::BUCKETS_RESET;
			run_q      <= shb_pkg::ALL_ONES;
			at_start_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					shb_pkg::CFG_IDX_MODE:    mode_q    <= cfg_data[shb_pkg::MODE_W-1:0];
					shb_pkg::CFG_IDX_BUCKETS: buckets_q <= cfg_data;
					default:                  mode_q    <= mode_q;
				endcase
			end
			if (cmd.fold) begin
				run_q      <= fold_byte(mode_q, base, char_byte, at_start_q);
				at_start_q <= 1'b0;
			end else if (cmd.start) begin
				run_q      <= init_for(mode_q);
				at_start_q <= 1'b1;
			end
		end
	end

	// restoring remainder, one dividend bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hash_q <= final_hash;
			dvd_q  <= final_hash;
			dsr_q  <= buckets_q;
			rem_q  <= '0;
		end else if (cmd.step) begin
			dvd_q <= dvd_q << 1;
			if (trial >= {1'b0, dsr_q})
				rem_q <= diff[shb_pkg::BUCKET_W-1:0];
			else
				rem_q <= trial[shb_pkg::BUCKET_W-1:0];
		end
		if (cmd.commit) begin
			hash_out_q   <= hash_q;
			bucket_out_q <= (dsr_q == '0) ? '0 : rem_q;
		end
	end

	assign hash_value   = hash_out_q;
	assign bucket_index = bucket_out_q;

endmodule

>>> sv/string_hash_bucket_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash_bucket_core
// Multi-mode 32-bit word hash with bucket index (hash mod bucket count).
// ----------------------------------------------------------------------------
// Usage:
//  - char_ch carries one byte per request; a zero byte ends the word.
//  - result_ch carries hash_value and bucket_index, one request per word.
//  - Config: cfg_we/cfg_index/cfg_data; index 0 hash mode, 1 bucket count.
//    Write only while the block is idle.
// Timing:
//  - Non-zero bytes: one per cycle while idle, folded into the running hash at once.
//  - Terminator: bit-serial remainder (one dividend bit a cycle), then a
//    hand-off state that loads the result register when it is free; result
//    valid the cycle after the load. char_ch.ready is low throughout.
//  - Result sits in an output register; the next word's bytes are taken
//    while it waits. A stalled receiver holds the next terminator in the
//    hand-off state until the register frees.
// Reset: mode CRC-32, 1024 buckets, running hash all ones, no result held.
// ----------------------------------------------------------------------------
module string_hash_bucket_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [shb_pkg::BUCKET_W-1:0]  cfg_data,
	shb_char_if.sink                      char_ch,
	shb_result_if.source                  result_ch
);

	shb_pkg::shb_cmd_t cmd;   // controller -> datapath
	shb_pkg::shb_sts_t sts;   // datapath -> controller

	// sequencer: decides when a request is taken and when the result loads
	shb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (char_ch.valid),
		.in_ready  (char_ch.ready),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// hash fold, remainder unit and result register
	shb_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.char_byte    (char_ch.char_byte),
		.cmd          (cmd),
		.sts          (sts),
		.hash_value   (result_ch.hash_value),
		.bucket_index (result_ch.bucket_index)
	);

endmodule

>>> test/shb_hash_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_hash_checker
// Watches the byte, result and register ports and predicts each word's hash
// and bucket. Every result request is compared, field by field, with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module shb_hash_checker
	import shb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [BUCKET_W-1:0] cfg_data,
	shb_char_if                 char_ch,
	shb_result_if               result_ch,
	output int unsigned         fail_count,
	output int unsigned         outstanding
);

	typedef struct packed {
		logic [HASH_W-1:0]   hash_value;
		logic [BUCKET_W-1:0] bucket_index;
	} word_result_t;

	word_result_t        expected_words[$];
	logic [MODE_W-1:0]   mode_q;
	logic [BUCKET_W-1:0] buckets_q;
	logic [HASH_W-1:0]   word_hash;
	logic                word_start;

	task automatic report_mismatch(input string what, input logic [HASH_W-1:0] got,
			input logic [HASH_W-1:0] want);
		if (fail_count < 50)
			$display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		logic [HASH_W-1:0] done_hash;
		logic [HASH_W-1:0] next_hash;
		logic [CHAR_W-1:0] c;
		word_result_t      want;
		if (!arst_n) begin
			mode_q      = MODE_RESET;
			buckets_q   = BUCKETS_RESET;
			word_hash   = ALL_ONES;
			word_start  = 1'b1;
			expected_words.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_IDX_MODE:    mode_q = cfg_data[MODE_W-1:0];
					CFG_IDX_BUCKETS: buckets_q = cfg_data;
				endcase
			end

			if (result_ch.valid && result_ch.ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("result with no word pending", result_ch.hash_value, '0);
				end else begin
					want = expected_words.pop_front();
					if (result_ch.hash_value !== want.hash_value)
						report_mismatch("hash_value", result_ch.hash_value, want.hash_value);
					if (result_ch.bucket_index !== want.bucket_index)
						report_mismatch("bucket_index", HASH_W'(result_ch.bucket_index),
							HASH_W'(want.bucket_index));
				end
			end

			if (char_ch.valid && char_ch.ready) begin
				c = char_ch.char_byte;
				if (c != '0) begin
					// start value taken from the mode at the first byte
					if (word_start)
						word_hash = (mode_q == MODE_CRC32) ? ALL_ONES : '0;
					case (mode_q)
						MODE_FIRST: next_hash = word_start ? HASH_W'(c) : word_hash;
						MODE_SUM:   next_hash = word_hash + HASH_W'(c);
						MODE_XOR:   next_hash = word_hash ^ HASH_W'(c);
						MODE_ROTL:  next_hash = {word_hash[HASH_W-2:0], word_hash[HASH_W-1]}
							^ HASH_W'(c);
						MODE_ROTR:  next_hash = {word_hash[0], word_hash[HASH_W-1:1]}
							^ HASH_W'(c);
						MODE_CRC32: begin
							next_hash = word_hash ^ HASH_W'(c);
							for (int k = 0; k < CHAR_W; k++)
								next_hash = next_hash[0] ? ((next_hash >> 1) ^ CRC_POLY)
									: (next_hash >> 1);
						end
						default:    next_hash = '0;
					endcase
					word_hash  = next_hash;
					word_start = 1'b0;
				end else begin
					// inversion only if CRC-32 is in force at the terminator
					if (word_start)
						done_hash = '0;
					else if (mode_q == MODE_CRC32)
						done_hash = ~word_hash;
					else
						done_hash = word_hash;
					want.hash_value   = done_hash;
					want.bucket_index = (buckets_q != '0)
						? BUCKET_W'(done_hash % HASH_W'(buckets_q)) : '0;
					expected_words.push_back(want);
					word_hash  = (mode_q == MODE_CRC32) ? ALL_ONES : '0;
					word_start = 1'b1;
				end
			end
			outstanding <= expected_words.size();
		end
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for string_hash_bucket_core. A directed tour of the
// modes and bucket extremes is followed by three randomised phases of words
// with varying idling on each side; the checker beside the block predicts
// and compares every result request.
// ----------------------------------------------------------------------------
module tb;
	import shb_pkg::*;

	// code 7 names no mode; the block treats it as the zero hash
	localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

	// covers a terminator's remainder and hand-off, with a little margin on top
	localparam int unsigned DRAIN_CYCLES     = 40;
	// long enough for a result and a held terminator to back up the input
	localparam int unsigned LONG_HOLD_CYCLES = 400;
	localparam int unsigned PHASE_REQUESTS   = 640;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [0:0]          cfg_index;
	logic [BUCKET_W-1:0] cfg_data;

	shb_char_if   char_ch();
	shb_result_if result_ch();

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned chars_sent;
	logic        hold_request = 1'b0;

	string_hash_bucket_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.char_ch   (char_ch),
		.result_ch (result_ch)
	);

	shb_hash_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.char_ch     (char_ch),
		.result_ch   (result_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Generous cap: the slowest legal run is well under a tenth of this.
	initial begin : watchdog
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// One byte request. A random idle gap comes first (valid low), then valid
	// stays up until the block takes the byte. Valid is left high on return so
	// that back-to-back requests need no low cycle in between.
	task automatic send_char(input logic [CHAR_W-1:0] c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			char_ch.valid <= 1'b0;
			@(posedge clk);
		end
		char_ch.valid     <= 1'b1;
		char_ch.char_byte <= c;
		do
			@(posedge clk);
		while (char_ch.ready !== 1'b1);
		chars_sent++;
	endtask

	// Random non-zero body; the terminator is optional so that a word can be
	// left open across a register write.
	task automatic send_word(input int unsigned len, input bit terminate);
		repeat (len)
			send_char(CHAR_W'($urandom_range(1, 255)));
		if (terminate)
			send_char('0);
	endtask

	// Bring the block to rest: stop offering bytes, wait for every predicted
	// result, then give the divider time to finish anything still in flight.
	// The first edge lets a terminator taken on the last edge show up in the
	// outstanding count.
	task automatic settle();
		char_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Write enable high for one edge, then a low edge, so two writes in a row
	// never assign cfg_we twice in one step.
	task automatic write_reg(input logic [0:0] idx, input logic [BUCKET_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// A randomised phase: short bursts of words under a fresh setting each
	// time. Mode writes carry junk in the unused upper bits; bucket counts hit
	// zero, one and the maximum often.
	task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct);
		int unsigned         stop_at;
		int unsigned         pick;
		logic [BUCKET_W-1:0] buckets;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		stop_at       = chars_sent + PHASE_REQUESTS;
		// quiet block first, so the hold below lands on fresh traffic
		settle();
		// receiver shuts off for a long stretch while bytes keep coming, so
		// the result register fills and the input stalls
		hold_request  = 1'b1;
		while (chars_sent < stop_at) begin
			pick = $urandom_range(0, 3);
			if (pick != 0)
				write_reg(CFG_IDX_MODE, {(BUCKET_W-MODE_W)'($urandom),
					MODE_W'($urandom_range(MODE_ZERO, MODE_UNUSED))});
			if (pick != 1) begin
				case ($urandom_range(0, 5))
					0:       buckets = '0;
					1:       buckets = BUCKET_W'(1);
					2:       buckets = '1;
					3:       buckets = BUCKET_W'($urandom_range(2, 64));
					default: buckets = BUCKET_W'($urandom);
				endcase
				write_reg(CFG_IDX_BUCKETS, buckets);
			end
			// mostly short words, now and then a long one; length 0 is an
			// empty word
			repeat ($urandom_range(4, 12))
				send_word(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
					: $urandom_range(0, 8), 1'b1);
			// leave a word open now and then: the next setting lands mid-word
			if ($urandom_range(0, 2) == 0)
				send_word($urandom_range(1, 4), 1'b0);
			settle();
		end
	endtask

	// Result side: random ready each cycle, or a long counted hold on request.
	initial begin : result_receiver
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES)
					@(posedge clk);
				hold_request = 1'b0;
			end
			result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			@(posedge clk);
		end
	end

	initial begin : stimulus
		logic [MODE_W-1:0]   tour_mode[6];
		logic [BUCKET_W-1:0] tour_buckets[6];
		tour_mode    = '{MODE_ZERO, MODE_FIRST, MODE_SUM, MODE_ROTL, MODE_ROTR, MODE_UNUSED};
		tour_buckets = '{16'd1, 16'hFFFF, 16'd0, 16'd1000, 16'hFFFF, 16'd0};

		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= CFG_IDX_MODE;
		cfg_data          <= '0;
		char_ch.valid     <= 1'b0;
		char_ch.char_byte <= '0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling. Reset setting (CRC-32, 1024 buckets):
		// byte extremes, then an empty word.
		send_char(8'h80);
		send_char(8'h01);
		send_char(8'hFF);
		send_char(8'h00);
		send_char(8'h00);

		// word opened under CRC-32, finished under xor: all-ones start value
		// stays, final inversion does not happen
		send_char(8'h11);
		settle();
		write_reg(CFG_IDX_MODE, BUCKET_W'(MODE_XOR));
		send_char(8'h22);
		send_char(8'h00);

		// every other mode once, the unused code among them, with bucket
		// counts at one, maximum, zero and 1000
		foreach (tour_mode[i]) begin
			settle();
			write_reg(CFG_IDX_MODE, BUCKET_W'(tour_mode[i]));
			write_reg(CFG_IDX_BUCKETS, tour_buckets[i]);
			send_char(8'hFF);
			send_char(8'h7F);
			send_char(8'h00);
		end

		// random phases: receiver-heavy idling, sender-heavy, then none
		run_phase(34, 61);
		run_phase(61, 34);
		run_phase(0, 0);

		// drain and let any late, unpredicted result show up
		settle();
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+sv
sv/shb_pkg.sv
sv/shb_if.sv
sv/shb_ctrl.sv
sv/shb_dpath.sv
sv/string_hash_bucket_core.sv
test/shb_hash_checker.sv
test/tb.sv
